// ===== rtl/assert_macros.svh =====
// Assertion macros used by the fin mixer top level.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FMX_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fin mixer check failed");

// next-cycle implication
`define FMX_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fin mixer sequence check failed");

`endif

// ===== rtl/fmx_pkg.sv =====
// Constants and tables of the cruciform fin mixer.
// No dependencies; used by fmx_sin, fmx_div and cruciform_fin_mixer.
package fmx_pkg;

  localparam int FIN_COUNT = 4;

  localparam logic       REG_MAX_FIN   = 1'b0;
  localparam logic       REG_THRUST_EN = 1'b1;
  localparam logic [13:0] LIM_RESET    = 14'd1430;

  localparam logic signed [31:0] C1  = 32'sd1686629713;
  localparam logic signed [31:0] C3  = -32'sd693598668;
  localparam logic signed [31:0] C5  = 32'sd85569306;
  localparam logic signed [31:0] C7  = -32'sd5026995;
  localparam logic signed [31:0] C9  = 32'sd172272;
  localparam logic signed [31:0] C11 = -32'sd3864;

  localparam logic [30:0] KRAD = 31'd1199381129;

  // floor(a / 45) = (a * RECIP45) >> RECIP_SH for a up to 11520
  localparam logic [19:0] RECIP45  = 20'd745655;
  localparam int          RECIP_SH = 25;

  localparam int SIN_LAT = 9;
  localparam int QW      = 14;
  localparam int NUM_W   = 50;
  localparam int DEN_W   = 35;
  localparam int MAG_W   = 34;

  typedef logic [21:0] rtab_t [45];

  function automatic rtab_t rtab_init();
    rtab_t t;
    for (int r = 0; r < 45; r++) begin
      t[r] = 22'((64'(r) << 22) / 45);
    end
    return t;
  endfunction

  // floor(r * 2^22 / 45) for remainders of the angle by 45
  localparam rtab_t RTAB = rtab_init();

endpackage

// ===== rtl/cruciform_fin_mixer.sv =====
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Depth: entry, the two sine pipelines (9), mixing, 14-stage divider, output.
// out_valid is a one-cycle strobe; the receiver cannot hold results off.
// Reset clears all valid bits and sets max_fin_angle 1430, thrust_enable 0.
// Top level; depends on fmx_pkg, fmx_sin, fmx_div and assert_macros.svh.
`include "assert_macros.svh"
module cruciform_fin_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_roll_cmd,
  input  logic signed [15:0] in_pitch_cmd,
  input  logic signed [15:0] in_yaw_cmd,
  input  logic signed [15:0] in_current_roll,
  input  logic signed [15:0] in_thrust_in,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [13:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [14:0] out_fin_bottom_starboard,
  output logic signed [14:0] out_fin_top_starboard,
  output logic signed [14:0] out_fin_bottom_port,
  output logic signed [14:0] out_fin_top_port,
  output logic signed [15:0] out_thrust_out,
  output logic               out_thrust_valid
);
  import fmx_pkg::*;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] thrust;
    logic [13:0]        lim;
    logic               ten;
  } front_t;

  typedef struct packed {
    logic signed [15:0] thrust;
    logic [13:0]        lim;
    logic               ten;
  } side_t;

  typedef struct packed {
    side_t                 sd;
    logic [FIN_COUNT-1:0]  sg;
    logic                  limf;
    logic [FIN_COUNT-1:0][18:0] rnd;
  } tail_t;

  // configuration
  logic [13:0] lim_r;
  logic        ten_r;

  // entry stage
  logic               t0_vld_r;
  logic signed [15:0] croll_r;
  front_t             t0_r;
  front_t             fd_r [SIN_LAT];

  // angle wrap and fold
  logic signed [16:0] aw_w;
  logic signed [16:0] af_w;
  logic signed [16:0] aa_w;
  logic               negc_w;

  logic               sin_vld;
  logic               cos_vld;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;

  // mixing stages
  logic [8:0]         v_r;
  side_t              md_r [9];
  logic signed [15:0] roll1_r;
  logic signed [47:0] yc_r, ps_r, ys_r, pc_r;
  logic signed [50:0] f_r  [FIN_COUNT];
  logic [MAG_W-1:0]   q_r  [FIN_COUNT];
  logic [FIN_COUNT-1:0] sg_r [7];
  logic [47:0]        lo_r [FIN_COUNT];
  logic [47:0]        hi_r [FIN_COUNT];
  logic [MAG_W-1:0]   mag5_r [FIN_COUNT];
  logic [MAG_W-1:0]   mag6_r [FIN_COUNT];
  logic [MAG_W-1:0]   mag7_r [FIN_COUNT];
  logic [MAG_W-1:0]   m01_r, m23_r, big7_r, big8_r;
  logic [47:0]        prd_r [FIN_COUNT];
  logic [FIN_COUNT-1:0][18:0] rnd8_r;
  logic [FIN_COUNT-1:0][18:0] rnd9_r;
  logic               limf8_r, limf9_r;
  logic [NUM_W-1:0]   num_r [FIN_COUNT];
  logic [DEN_W-1:0]   den_r;

  // divider and tail
  logic [FIN_COUNT-1:0] dv_vld;
  logic [QW-1:0]        quo   [FIN_COUNT];
  tail_t                tl_r  [QW];

  logic signed [50:0] ry_w, rp_w, rq_w;
  logic signed [50:0] fa_w [FIN_COUNT];
  logic [64:0]        pr_w [FIN_COUNT];
  logic [18:0]        mm_w [FIN_COUNT];
  logic [13:0]        mc_w [FIN_COUNT];
  logic signed [14:0] fin_w [FIN_COUNT];

  // outputs
  logic               out_valid_r;
  logic signed [14:0] fin_r [FIN_COUNT];
  logic signed [15:0] thr_o_r;
  logic               ten_o_r;
  logic [13:0]        lim_o_r;
  logic               limf_o_r;
  logic [QW-1:0]      quo0_o_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RESET;
      ten_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_FIN:   lim_r <= cfg_wdata;
        REG_THRUST_EN: ten_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // wrap roll once by 360 degrees, fold into +-90, negate cosine when folded
  always_comb begin
    aw_w = 17'(croll_r);
    if (aw_w > 17'sd23040) begin
      aw_w = aw_w - 17'sd46080;
    end else if (aw_w < -17'sd23040) begin
      aw_w = aw_w + 17'sd46080;
    end
    negc_w = 1'b0;
    if (aw_w > 17'sd11520) begin
      af_w   = 17'sd23040 - aw_w;
      negc_w = 1'b1;
    end else if (aw_w < -17'sd11520) begin
      af_w   = -17'sd23040 - aw_w;
      negc_w = 1'b1;
    end else begin
      af_w = aw_w;
    end
    aa_w = (af_w < 0) ? -af_w : af_w;
  end

  fmx_sin u_sin (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t0_vld_r),
    .in_ang  (aa_w[13:0]),
    .in_neg  (af_w < 0),
    .out_vld (sin_vld),
    .out_sin (sin_q)
  );

  fmx_sin u_cos (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t0_vld_r),
    .in_ang  (14'(17'sd11520 - aa_w)),
    .in_neg  (negc_w),
    .out_vld (cos_vld),
    .out_sin (cos_q)
  );

  always_comb begin
    ry_w = 51'(yc_r) - 51'(ps_r);
    rp_w = 51'(ys_r) + 51'(pc_r);
    rq_w = 51'(roll1_r) <<< 30;
    for (int i = 0; i < FIN_COUNT; i++) begin
      fa_w[i] = (f_r[i] < 0) ? -f_r[i] : f_r[i];
      pr_w[i] = 65'(lo_r[i]) + (65'(hi_r[i]) << 17);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_vld_r <= 1'b0;
      v_r      <= '0;
    end else begin
      t0_vld_r <= start && !busy;
      v_r      <= {v_r[7:0], sin_vld && cos_vld};
    end
  end

  always_ff @(posedge clk) begin
    croll_r    <= in_current_roll;
    t0_r       <= '{roll: in_roll_cmd, pitch: in_pitch_cmd, yaw: in_yaw_cmd,
                    thrust: in_thrust_in, lim: lim_r, ten: ten_r};
    fd_r[0]    <= t0_r;
    for (int i = 1; i < SIN_LAT; i++) begin
      fd_r[i] <= fd_r[i-1];
    end

    // rotate pitch and yaw by the roll
    yc_r    <= fd_r[SIN_LAT-1].yaw * cos_q;
    ps_r    <= fd_r[SIN_LAT-1].pitch * sin_q;
    ys_r    <= fd_r[SIN_LAT-1].yaw * sin_q;
    pc_r    <= fd_r[SIN_LAT-1].pitch * cos_q;
    roll1_r <= fd_r[SIN_LAT-1].roll;
    md_r[0] <= '{thrust: fd_r[SIN_LAT-1].thrust, lim: fd_r[SIN_LAT-1].lim,
                 ten: fd_r[SIN_LAT-1].ten};
    for (int i = 1; i < 9; i++) begin
      md_r[i] <= md_r[i-1];
    end

    // mix into four fins
    f_r[0] <= rp_w - ry_w + rq_w;
    f_r[1] <= rp_w + ry_w + rq_w;
    f_r[2] <= -rp_w - ry_w + rq_w;
    f_r[3] <= -rp_w + ry_w + rq_w;

    for (int i = 0; i < FIN_COUNT; i++) begin
      q_r[i]    <= fa_w[i][MAG_W+13:14];
      sg_r[0][i] <= f_r[i] < 0;
      lo_r[i]   <= 48'(q_r[i][16:0]) * 48'(KRAD);
      hi_r[i]   <= 48'(q_r[i][MAG_W-1:17]) * 48'(KRAD);
      mag5_r[i] <= pr_w[i][MAG_W+29:30];
      mag6_r[i] <= mag5_r[i];
      mag7_r[i] <= mag6_r[i];
      prd_r[i]  <= 48'(mag7_r[i]) * 48'(md_r[6].lim);
      rnd8_r[i] <= 19'((35'(mag7_r[i]) + 35'd32768) >> 16);
      num_r[i]  <= 50'({prd_r[i], 1'b0}) + 50'(big8_r);
    end
    for (int i = 1; i < 7; i++) begin
      sg_r[i] <= sg_r[i-1];
    end

    // largest magnitude
    m01_r   <= (mag5_r[0] > mag5_r[1]) ? mag5_r[0] : mag5_r[1];
    m23_r   <= (mag5_r[2] > mag5_r[3]) ? mag5_r[2] : mag5_r[3];
    big7_r  <= (m01_r > m23_r) ? m01_r : m23_r;
    big8_r  <= big7_r;
    limf8_r <= big7_r > MAG_W'({md_r[6].lim, 16'd0});

    rnd9_r  <= rnd8_r;
    limf9_r <= limf8_r;
    den_r   <= {big8_r, 1'b0};

    tl_r[0] <= '{sd: md_r[8], sg: sg_r[6], limf: limf9_r, rnd: rnd9_r};
    for (int i = 1; i < QW; i++) begin
      tl_r[i] <= tl_r[i-1];
    end
  end

  for (genvar g = 0; g < FIN_COUNT; g++) begin : g_div
    fmx_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (v_r[8]),
      .in_num  (num_r[g]),
      .in_den  (den_r),
      .out_vld (dv_vld[g]),
      .out_quo (quo[g])
    );
  end

  // select, clamp, restore sign
  always_comb begin
    for (int i = 0; i < FIN_COUNT; i++) begin
      mm_w[i] = tl_r[QW-1].limf ? 19'(quo[i]) : tl_r[QW-1].rnd[i];
      mc_w[i] = (mm_w[i] > 19'(tl_r[QW-1].sd.lim)) ? tl_r[QW-1].sd.lim : mm_w[i][13:0];
      fin_w[i] = tl_r[QW-1].sg[i] ? -$signed({1'b0, mc_w[i]}) : $signed({1'b0, mc_w[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIN_COUNT; i++) begin
      fin_r[i] <= fin_w[i];
    end
    thr_o_r  <= tl_r[QW-1].sd.ten ? tl_r[QW-1].sd.thrust : 16'sd0;
    ten_o_r  <= tl_r[QW-1].sd.ten;
    lim_o_r  <= tl_r[QW-1].sd.lim;
    limf_o_r <= tl_r[QW-1].limf;
    quo0_o_r <= quo[0];
  end

  assign out_valid                = out_valid_r;
  assign out_fin_bottom_starboard = fin_r[0];
  assign out_fin_top_starboard    = fin_r[1];
  assign out_fin_bottom_port      = fin_r[2];
  assign out_fin_top_port         = fin_r[3];
  assign out_thrust_out           = thr_o_r;
  assign out_thrust_valid         = ten_o_r;

  `FMX_CHK_IMP(a_fin_in_limit, out_valid_r, (fin_r[0] <= $signed({1'b0, lim_o_r})) && (fin_r[0] >= -$signed({1'b0, lim_o_r})))
  `FMX_CHK_IMP(a_thrust_gated, out_valid_r, ten_o_r || (thr_o_r == 16'sd0))
  `FMX_CHK_IMP(a_quo_in_limit, out_valid_r && limf_o_r, quo0_o_r <= lim_o_r)
  `FMX_CHK_NXT(a_div_feeds_out, dv_vld[0], out_valid_r)

endmodule

// ===== rtl/fmx_sin.sv =====
// Pipelined sine of a folded angle in 1/128 degree, Q30 result.
// Depends on fmx_pkg; odd polynomial by Horner, one product per stage.
module fmx_sin (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [13:0]        in_ang,
  input  logic               in_neg,
  output logic               out_vld,
  output logic signed [31:0] out_sin
);
  import fmx_pkg::*;

  logic [SIN_LAT-1:0]  vld_r;
  logic [SIN_LAT-1:0]  neg_r;
  logic [33:0]         kp_r;
  logic [13:0]         ang_r;
  logic [30:0]         xa_r;
  logic [30:0]         x_r  [7];
  logic [30:0]         x2_r [5];
  logic signed [31:0]  p_r  [5];
  logic signed [31:0]  sin_r;

  logic [8:0]          k_w;
  logic [13:0]         r_w;
  logic [61:0]         xx_w;

  localparam logic signed [31:0] COEF [5] = '{C9, C7, C5, C3, C1};

  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] p,
                                                 input logic [30:0] v);
    logic signed [63:0] pr;
    logic signed [63:0] q;
    pr = p * $signed({1'b0, v});
    q  = pr >>> 30;
    if (pr < 0 && pr[29:0] != 30'd0) begin
      q = q + 64'sd1;
    end
    return q[31:0];
  endfunction

  always_comb begin
    k_w  = kp_r[33:RECIP_SH];
    r_w  = ang_r - 14'(k_w * 6'd45);
    xx_w = 62'(xa_r) * 62'(x_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SIN_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= {neg_r[SIN_LAT-2:0], in_neg};
    kp_r   <= 34'(in_ang) * 34'(RECIP45);
    ang_r  <= in_ang;
    xa_r   <= {k_w, 22'd0} + 31'(RTAB[r_w[5:0]]);
    x_r[0] <= {k_w, 22'd0} + 31'(RTAB[r_w[5:0]]);
    x2_r[0] <= xx_w[60:30];
    x_r[1]  <= x_r[0];
    p_r[0]  <= COEF[0] + mul_q30(C11, x2_r[0]);
    x_r[2]  <= x_r[1];
    x2_r[1] <= x2_r[0];
    for (int j = 1; j < 5; j++) begin
      p_r[j] <= COEF[j] + mul_q30(p_r[j-1], x2_r[j]);
    end
    for (int j = 2; j < 5; j++) begin
      x2_r[j] <= x2_r[j-1];
    end
    for (int j = 3; j < 7; j++) begin
      x_r[j] <= x_r[j-1];
    end
    sin_r <= neg_r[SIN_LAT-2] ? -mul_q30(p_r[4], x_r[6]) : mul_q30(p_r[4], x_r[6]);
  end

  assign out_vld = vld_r[SIN_LAT-1];
  assign out_sin = sin_r;

endmodule

// ===== rtl/fmx_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on fmx_pkg for widths; quotient valid when num / den < 2^QW.
module fmx_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [fmx_pkg::NUM_W-1:0] in_num,
  input  logic [fmx_pkg::DEN_W-1:0] in_den,
  output logic                     out_vld,
  output logic [fmx_pkg::QW-1:0]    out_quo
);
  import fmx_pkg::*;

  logic [QW-1:0]    vld_r;
  logic [DEN_W-1:0] rem_r [QW];
  logic [QW-1:0]    quo_r [QW];
  logic [QW-1:0]    low_r [QW];
  logic [DEN_W-1:0] den_r [QW];

  logic [DEN_W-1:0] rem_in [QW];
  logic [QW-1:0]    quo_in [QW];
  logic [QW-1:0]    low_in [QW];
  logic [DEN_W-1:0] den_in [QW];
  logic [DEN_W:0]   trl_w  [QW];
  logic             ge_w   [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rem_in[i] = in_num[QW+DEN_W-1:QW];
        quo_in[i] = '0;
        low_in[i] = in_num[QW-1:0];
        den_in[i] = in_den;
      end else begin
        rem_in[i] = rem_r[i-1];
        quo_in[i] = quo_r[i-1];
        low_in[i] = low_r[i-1];
        den_in[i] = den_r[i-1];
      end
      trl_w[i] = {rem_in[i], low_in[i][QW-1]};
      ge_w[i]  = trl_w[i] >= {1'b0, den_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW; i++) begin
      rem_r[i] <= ge_w[i] ? DEN_W'(trl_w[i] - {1'b0, den_in[i]}) : trl_w[i][DEN_W-1:0];
      quo_r[i] <= {quo_in[i][QW-2:0], ge_w[i]};
      low_r[i] <= {low_in[i][QW-2:0], 1'b0};
      den_r[i] <= den_in[i];
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = quo_r[QW-1];

endmodule
